FILE: hdl/ctse_pkg.sv
// types, constants and the digit limit function shared by the clock time-set editor modules
// no dependencies
package ctse_pkg;

  localparam int DIGIT_COUNT = 6;
  localparam int CURSOR_W = 3;
  localparam int KEY_W = 5;

  localparam logic [KEY_W-1:0] KEY_SAVE = 5'd10;
  localparam logic [KEY_W-1:0] KEY_NEXT = 5'd11;
  localparam logic [KEY_W-1:0] KEY_PREV = 5'd12;
  localparam logic [KEY_W-1:0] KEY_EDIT = 5'd17;
  localparam logic [KEY_W-1:0] KEY_DIGIT_END = 5'd10;

  localparam logic [CURSOR_W-1:0] CURSOR_FIRST = 3'd0;
  localparam logic [CURSOR_W-1:0] CURSOR_LAST = 3'(DIGIT_COUNT - 1);

  localparam logic [CURSOR_W-1:0] POS_HOUR_TENS = 3'd0;
  localparam logic [CURSOR_W-1:0] POS_HOUR_UNITS = 3'd1;
  localparam logic [CURSOR_W-1:0] POS_MIN_TENS = 3'd2;
  localparam logic [CURSOR_W-1:0] POS_SEC_TENS = 3'd4;

  localparam logic [3:0] LIMIT_HOUR_TENS = 4'd3;
  localparam logic [3:0] LIMIT_HOUR_UNITS_LATE = 4'd4;
  localparam logic [3:0] LIMIT_TENS = 4'd6;
  localparam logic [3:0] LIMIT_UNITS = 4'd10;
  localparam logic [3:0] HOUR_TENS_LATE = 4'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [7:0]       clock_hours;
    logic [7:0]       clock_minutes;
    logic [7:0]       clock_seconds;
  } key_req_t;

  typedef struct packed {
    logic                write_valid;
    logic [7:0]          write_hours;
    logic [7:0]          write_minutes;
    logic [7:0]          write_seconds;
    logic                editing;
    logic [CURSOR_W-1:0] cursor_position;
  } edit_result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  function automatic logic [3:0] digit_limit(input logic [CURSOR_W-1:0] pos,
                                             input logic [3:0] hour_tens);
    logic [3:0] lim;
    case (pos)
      POS_HOUR_TENS:  lim = LIMIT_HOUR_TENS;
      POS_HOUR_UNITS: lim = (hour_tens == HOUR_TENS_LATE) ? LIMIT_HOUR_UNITS_LATE
                                                          : LIMIT_UNITS;
      POS_MIN_TENS:   lim = LIMIT_TENS;
      POS_SEC_TENS:   lim = LIMIT_TENS;
      default:        lim = LIMIT_UNITS;
    endcase
    return lim;
  endfunction

endpackage

FILE: hdl/ctse_input_stage.sv
// input register for key requests
// depends on ctse_pkg
module ctse_input_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  output logic               key_stall,
  input  ctse_pkg::key_req_t key_req,
  input  logic               advance,
  output ctse_pkg::stage_ctrl_t ctrl,
  output ctse_pkg::key_req_t held
);
  import ctse_pkg::*;

  logic full;

  assign key_stall = full && !advance;
  assign ctrl.valid = full;
  assign ctrl.advance = full && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!key_stall) begin
      full <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!key_stall && key_valid) begin
      held <= key_req;
    end
  end

endmodule

FILE: hdl/ctse_editor.sv
// edit state (mode, cursor, digit store) and the per-key update
// depends on ctse_pkg
module ctse_editor (
  input  logic                    clk,
  input  logic                    rst,
  input  ctse_pkg::stage_ctrl_t   ctrl,
  input  ctse_pkg::key_req_t      held,
  output ctse_pkg::edit_result_t  result_next
);
  import ctse_pkg::*;

  logic                edit_mode, edit_mode_next;
  logic [CURSOR_W-1:0] cursor, cursor_next;
  logic [3:0]          digit_store [DIGIT_COUNT];
  logic [3:0]          digit_store_next [DIGIT_COUNT];
  logic [3:0]          limit;

  assign limit = digit_limit(cursor, digit_store[0]);

  always_comb begin
    edit_mode_next = edit_mode;
    cursor_next = cursor;
    digit_store_next = digit_store;
    result_next.write_valid = 1'b0;
    result_next.write_hours = '0;
    result_next.write_minutes = '0;
    result_next.write_seconds = '0;
    if (!edit_mode) begin
      if (held.key_code == KEY_EDIT) begin
        digit_store_next[0] = held.clock_hours[7:4];
        digit_store_next[1] = held.clock_hours[3:0];
        digit_store_next[2] = held.clock_minutes[7:4];
        digit_store_next[3] = held.clock_minutes[3:0];
        digit_store_next[4] = held.clock_seconds[7:4];
        digit_store_next[5] = held.clock_seconds[3:0];
        cursor_next = CURSOR_FIRST;
        edit_mode_next = 1'b1;
      end
    end else if (held.key_code == KEY_NEXT) begin
      cursor_next = (cursor == CURSOR_LAST) ? CURSOR_FIRST : cursor + 3'd1;
    end else if (held.key_code == KEY_PREV) begin
      cursor_next = (cursor == CURSOR_FIRST) ? CURSOR_LAST : cursor - 3'd1;
    end else if (held.key_code == KEY_SAVE) begin
      result_next.write_valid = 1'b1;
      result_next.write_hours = {digit_store[0], digit_store[1]};
      result_next.write_minutes = {digit_store[2], digit_store[3]};
      result_next.write_seconds = {digit_store[4], digit_store[5]};
      edit_mode_next = 1'b0;
      cursor_next = CURSOR_FIRST;
    end else if (held.key_code == KEY_EDIT) begin
      edit_mode_next = 1'b0;
      cursor_next = CURSOR_FIRST;
    end else if (held.key_code < KEY_DIGIT_END) begin
      if (held.key_code[3:0] < limit) begin
        digit_store_next[cursor] = held.key_code[3:0];
      end
    end
    result_next.editing = edit_mode_next;
    result_next.cursor_position = edit_mode_next ? cursor_next : CURSOR_FIRST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_mode <= 1'b0;
      cursor <= CURSOR_FIRST;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store[i] <= '0;
      end
    end else if (ctrl.advance) begin
      edit_mode <= edit_mode_next;
      cursor <= cursor_next;
      digit_store <= digit_store_next;
    end
  end

endmodule

FILE: hdl/ctse_output_stage.sv
// result register toward the receiver
// depends on ctse_pkg
module ctse_output_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  ctse_pkg::stage_ctrl_t  ctrl,
  input  ctse_pkg::edit_result_t result_next,
  output logic                   advance,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ctse_pkg::edit_result_t result
);
  import ctse_pkg::*;

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      result <= result_next;
    end
  end

endmodule

FILE: hdl/clock_time_set_editor.sv
// top level of the keypad time-set editor for a bcd real-time clock
// depends on ctse_pkg, ctse_input_stage, ctse_editor, ctse_output_stage
//
// usage:
//   key request channel: key_valid / key_stall / key_req carry one key press
//   together with the current clock bytes. a request is taken at a rising
//   edge with key_valid high and key_stall low.
//   result channel: result_valid / result_stall / result carry one result per
//   request: the write strobe and packed bcd time on save, the edit flag and
//   the cursor position after the key.
//   an accepted request passes through the input register and then the result
//   register to the port. throughput: one request per cycle while the receiver
//   does not stall; the edit state updates as a request leaves the input
//   register, so the next request sees it right away.
//   reset (rst, synchronous): display mode, cursor 0, digit store zero,
//   both registers empty.
//   when the receiver stalls, the result holds; one more request waits in
//   the input register, after which key_stall rises until the result is taken.
module clock_time_set_editor (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    key_valid,
  output logic                    key_stall,
  input  ctse_pkg::key_req_t      key_req,
  output logic                    result_valid,
  input  logic                    result_stall,
  output ctse_pkg::edit_result_t  result
);
  import ctse_pkg::*;

  stage_ctrl_t  ctrl;
  key_req_t     held;
  edit_result_t result_next;
  logic         advance;

  ctse_input_stage u_input (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_req   (key_req),
    .advance   (advance),
    .ctrl      (ctrl),
    .held      (held)
  );

  ctse_editor u_editor (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .held        (held),
    .result_next (result_next)
  );

  ctse_output_stage u_output (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .result_next  (result_next),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_save_leaves_edit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_valid |-> !result.editing)
    else $error("save result still in edit mode");

  a_display_cursor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.editing |-> result.cursor_position == CURSOR_FIRST)
    else $error("cursor nonzero in display mode");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cursor_position <= CURSOR_LAST)
    else $error("cursor out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    key_stall |-> result_valid && result_stall)
    else $error("request stalled while result side free");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench for the keypad time-set editor: directed key sequences, back-pressure and random sessions
// results are checked against an in-bench model; depends on ctse_pkg and clock_time_set_editor
module testbench;
  import ctse_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic key_valid = 1'b0;
  logic key_stall;
  key_req_t key_req = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  edit_result_t result;

  edit_result_t expected_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // editor model state
  logic edit_active = 1'b0;
  logic [CURSOR_W-1:0] cursor_now = CURSOR_FIRST;
  logic [3:0] digit_reg [DIGIT_COUNT] = '{default: 4'd0};

  clock_time_set_editor dut (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_req(key_req),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic edit_result_t predict_edit(input key_req_t req);
    edit_result_t res;
    logic [3:0] lim;
    res = '0;
    if (!edit_active) begin
      if (req.key_code == KEY_EDIT) begin
        digit_reg[0] = req.clock_hours[7:4];
        digit_reg[1] = req.clock_hours[3:0];
        digit_reg[2] = req.clock_minutes[7:4];
        digit_reg[3] = req.clock_minutes[3:0];
        digit_reg[4] = req.clock_seconds[7:4];
        digit_reg[5] = req.clock_seconds[3:0];
        cursor_now = CURSOR_FIRST;
        edit_active = 1'b1;
      end
    end else begin
      case (req.key_code)
        KEY_NEXT: cursor_now = (cursor_now == CURSOR_LAST) ? CURSOR_FIRST : cursor_now + 3'd1;
        KEY_PREV: cursor_now = (cursor_now == CURSOR_FIRST) ? CURSOR_LAST : cursor_now - 3'd1;
        KEY_SAVE: begin
          res.write_valid = 1'b1;
          res.write_hours = {digit_reg[0], digit_reg[1]};
          res.write_minutes = {digit_reg[2], digit_reg[3]};
          res.write_seconds = {digit_reg[4], digit_reg[5]};
          edit_active = 1'b0;
          cursor_now = CURSOR_FIRST;
        end
        KEY_EDIT: begin
          edit_active = 1'b0;
          cursor_now = CURSOR_FIRST;
        end
        default: begin
          if (req.key_code < KEY_DIGIT_END) begin
            case (cursor_now)
              POS_HOUR_TENS: lim = LIMIT_HOUR_TENS;
              POS_HOUR_UNITS: lim = (digit_reg[POS_HOUR_TENS] == HOUR_TENS_LATE) ?
                                    LIMIT_HOUR_UNITS_LATE : LIMIT_UNITS;
              POS_MIN_TENS, POS_SEC_TENS: lim = LIMIT_TENS;
              default: lim = LIMIT_UNITS;
            endcase
            if (req.key_code < lim) digit_reg[cursor_now] = req.key_code[3:0];
          end
        end
      endcase
    end
    res.editing = edit_active;
    res.cursor_position = edit_active ? cursor_now : CURSOR_FIRST;
    return res;
  endfunction

  function automatic logic [7:0] rand_clock_byte(input int max_tens);
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return {4'($urandom_range(max_tens)), 4'($urandom_range(9))};
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] code, input logic [7:0] hrs,
                          input logic [7:0] mins, input logic [7:0] secs);
    key_req_t req;
    req.key_code = code;
    req.clock_hours = hrs;
    req.clock_minutes = mins;
    req.clock_seconds = secs;
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      key_req <= key_req_t'($urandom);
      @(posedge clk);
    end
    key_req <= req;
    key_valid <= 1'b1;
    do @(posedge clk); while (key_stall);
    expected_results.push_back(predict_edit(req));
    items_sent++;
  endtask

  task automatic send_plain(input logic [KEY_W-1:0] code);
    send_key(code, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_results();
    key_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input edit_result_t got);
    edit_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no request pending, expected none actual %h", $time, got);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
      compare_field("write_hours", want.write_hours, got.write_hours);
      compare_field("write_minutes", want.write_minutes, got.write_minutes);
      compare_field("write_seconds", want.write_seconds, got.write_seconds);
      compare_field("editing", 8'(want.editing), 8'(got.editing));
      compare_field("cursor_position", 8'(want.cursor_position), 8'(got.cursor_position));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_display_ignore();
    send_plain(5'd0);
    send_plain(KEY_SAVE);
    send_plain(KEY_NEXT);
    send_plain(KEY_PREV);
    send_plain({KEY_W{1'b1}});
  endtask

  task automatic test_load_save();
    send_key(KEY_EDIT, 8'h23, 8'h59, 8'h59);
    send_plain(KEY_SAVE);
  endtask

  task automatic test_cursor_wrap();
    send_key(KEY_EDIT, 8'h00, 8'h00, 8'h00);
    send_plain(KEY_PREV);
    send_plain(KEY_NEXT);
    send_plain(KEY_NEXT);
    send_plain(KEY_EDIT);
  endtask

  task automatic test_digit_limits();
    // hour units 9 stays put when hour tens becomes 2; after that only digits below 4 are taken
    send_key(KEY_EDIT, 8'h19, 8'h45, 8'h30);
    send_plain(5'd3);
    send_plain(5'd2);
    send_plain(KEY_NEXT);
    send_plain(5'd4);
    send_plain(5'd3);
    send_plain(KEY_NEXT);
    send_plain(5'd6);
    send_plain(5'd5);
    send_plain(KEY_PREV + 5'd1);
    send_plain({KEY_W{1'b1}});
    send_plain(KEY_SAVE);
  endtask

  task automatic test_raw_nibbles();
    send_key(KEY_EDIT, 8'hFF, 8'hFA, 8'hAF);
    send_plain(KEY_SAVE);
  endtask

  task automatic random_session();
    int n;
    int r;
    logic [KEY_W-1:0] code;
    send_key(KEY_EDIT, rand_clock_byte(2), rand_clock_byte(5), rand_clock_byte(5));
    n = $urandom_range(1, 14);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55) code = KEY_W'($urandom_range(KEY_DIGIT_END - 1));
      else if (r < 75) code = KEY_NEXT;
      else if (r < 90) code = KEY_PREV;
      else begin
        code = KEY_W'($urandom_range(KEY_PREV + 1, {KEY_W{1'b1}}));
        if (code == KEY_EDIT) code = KEY_EDIT - 5'd1;
      end
      send_plain(code);
    end
    r = $urandom_range(99);
    if (r < 70) send_plain(KEY_SAVE);
    else if (r < 95) send_plain(KEY_EDIT);
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 200;
    random_session();
    random_session();
    wait_for_results();
  endtask

  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < items) begin
      if ($urandom_range(99) < 85) random_session();
      else send_plain(KEY_W'($urandom_range({KEY_W{1'b1}})));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_display_ignore();
    test_load_save();
    test_cursor_wrap();
    test_digit_limits();
    test_raw_nibbles();
    wait_for_results();
    test_back_pressure();
    test_random(400, 0, 0);
    test_random(400, 81, 0);
    test_random(400, 0, 81);
    test_random(400, 11, 11);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/ctse_pkg.sv
hdl/ctse_input_stage.sv
hdl/ctse_editor.sv
hdl/ctse_output_stage.sv
hdl/clock_time_set_editor.sv
test/testbench.sv
